### sv/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants of the voxel ray traversal block
// Field widths, time constants, axis and request codes and the sequencer
// state type.
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam int ORIG_W  = 22;
    localparam int DIR_W   = 16;
    localparam int CELL_W  = 6;
    localparam int RANGE_W = 6;
    localparam int TIME_W  = 32;

    localparam logic [TIME_W-1:0] TIME_ONE = 32'h0001_0000;
    localparam logic [TIME_W-1:0] TIME_MAX = 32'hFFFF_FFFF;

    localparam logic [RANGE_W-1:0] RANGE_RESET = 6'd10;

    localparam logic [1:0] AX_X    = 2'd0;
    localparam logic [1:0] AX_Y    = 2'd1;
    localparam logic [1:0] AX_Z    = 2'd2;
    localparam logic [1:0] AX_NONE = 2'd3;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CAST  = 1'b1;

    localparam logic REG_RAY_RANGE = 1'b0;

    typedef enum logic [13:0] {
        S_CLR  = 14'b00000000000001,
        S_IDLE = 14'b00000000000010,
        S_WRD  = 14'b00000000000100,
        S_WMOD = 14'b00000000001000,
        S_SQ   = 14'b00000000010000,
        S_SQRT = 14'b00000000100000,
        S_AXM  = 14'b00000001000000,
        S_DIVI = 14'b00000010000000,
        S_DIV  = 14'b00000100000000,
        S_CTM  = 14'b00001000000000,
        S_CTW  = 14'b00010000000000,
        S_RD   = 14'b00100000000000,
        S_TEST = 14'b01000000000000,
        S_FIN  = 14'b10000000000000
    } state_t;

endpackage

### sv/voxel_ray_traversal_top.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_top: occupancy grid with a voxel walking ray caster
// Write words set one voxel of the grid; cast words walk a segment of the
// grid with a 3D DDA and return the first solid voxel and its entry face.
//
//   channel   direction   handshake          carries
//   s_*       in          s_valid/s_ready    write or cast request word
//   m_*       out         m_valid/m_ready    hit, voxel and face normal word
//   apb       in          psel/penable       ray_range register at byte 0
//
// A write word reads, modifies and writes back one grid row. A cast word
// sums the squares of the direction, takes a bitwise square root, then for
// each nonzero direction axis runs multiply, divisor load, 32-step divide,
// scale and store, skips each zero axis, then tests voxels, one grid row
// read each, and loads the result.
// After reset the grid is swept to air, all GRID_SIDE*GRID_SIDE rows, one row
// a cycle, with s_ready low. A finished result waits in the output register;
// the next write word is taken meanwhile.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_top
    import vrt_pkg::*;
#(
    parameter int GRID_SIDE = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_req_type,
    input  logic [CELL_W-1:0]        s_cell_x,
    input  logic [CELL_W-1:0]        s_cell_y,
    input  logic [CELL_W-1:0]        s_cell_z,
    input  logic                     s_solid,
    input  logic [ORIG_W-1:0]        s_origin_x,
    input  logic [ORIG_W-1:0]        s_origin_y,
    input  logic [ORIG_W-1:0]        s_origin_z,
    input  logic signed [DIR_W-1:0]  s_dir_x,
    input  logic signed [DIR_W-1:0]  s_dir_y,
    input  logic signed [DIR_W-1:0]  s_dir_z,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_hit,
    output logic [CELL_W-1:0]        m_hit_x,
    output logic [CELL_W-1:0]        m_hit_y,
    output logic [CELL_W-1:0]        m_hit_z,
    output logic signed [1:0]        m_face_x,
    output logic signed [1:0]        m_face_y,
    output logic signed [1:0]        m_face_z
);

    localparam int CW   = $clog2(GRID_SIDE);
    localparam int AW   = 2 * CW;
    localparam int ROWS = GRID_SIDE * GRID_SIDE;
    localparam int IB   = (ORIG_W - FRAC_BITS > 8) ? (ORIG_W - FRAC_BITS) : 8;
    localparam int WCW  = IB + 2;
    localparam int OEW  = ORIG_W + FRAC_BITS;
    localparam int MB   = (FRAC_BITS + 1 > DIR_W) ? (FRAC_BITS + 1) : DIR_W;
    localparam int PW   = TIME_W + MB;
    localparam int DW   = 22;

    // Occupancy grid, one row of GRID_SIDE voxels per address {z, y}.
    logic [GRID_SIDE-1:0] occ_mem [ROWS];
    logic [GRID_SIDE-1:0] mem_rdata_reg;
    logic [GRID_SIDE-1:0] mem_wdata;
    logic [AW-1:0]        mem_addr;
    logic                 mem_we;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [RANGE_W-1:0]   range_reg;
    logic signed [WCW-1:0] wc_reg [3];
    logic signed [WCW-1:0] wc_next [3];
    logic [ORIG_W-1:0]    org_reg [3];
    logic [ORIG_W-1:0]    org_next [3];
    logic signed [DIR_W-1:0] dir_reg [3];
    logic signed [DIR_W-1:0] dir_next [3];
    logic                 solid_reg, solid_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic [1:0]           ax_reg, ax_next;
    logic [PW-1:0]        prod_reg, prod_next;
    logic [TIME_W-1:0]    sumsq_reg, sumsq_next;
    logic [63:0]          sq_n_reg, sq_n_next;
    logic [63:0]          sq_r_reg, sq_r_next;
    logic [63:0]          sq_b_reg, sq_b_next;
    logic [DW-1:0]        d_reg, d_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [TIME_W-1:0]    dq_reg, dq_next;
    logic [TIME_W-1:0]    cstep_reg [3];
    logic [TIME_W-1:0]    cstep_next [3];
    logic [TIME_W-1:0]    ctime_reg [3];
    logic [TIME_W-1:0]    ctime_next [3];
    logic [1:0]           last_ax_reg, last_ax_next;
    logic [7:0]           tests_reg, tests_next;
    logic [7:0]           limit_reg, limit_next;
    logic                 hit_reg, hit_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_hit_reg, m_hit_next;
    logic [CELL_W-1:0]    m_hx_reg, m_hx_next;
    logic [CELL_W-1:0]    m_hy_reg, m_hy_next;
    logic [CELL_W-1:0]    m_hz_reg, m_hz_next;
    logic signed [1:0]    m_fx_reg, m_fx_next;
    logic signed [1:0]    m_fy_reg, m_fy_next;
    logic signed [1:0]    m_fz_reg, m_fz_next;

    logic [DIR_W-1:0]     abs_dir [3];
    logic [FRAC_BITS:0]   plane_dist [3];
    logic signed [WCW-1:0] org_cell [3];
    logic [OEW-1:0]       oe_in [3];
    logic [OEW-1:0]       oe_reg [3];
    logic [TIME_W-1:0]    mul_a;
    logic [MB-1:0]        mul_b;
    logic [TIME_W-1:0]    sumsq_add;
    logic [63:0]          sq_t;
    logic [DW:0]          rem2;
    logic                 div_ge;
    logic                 in_grid;
    logic                 cell_ok;
    logic [1:0]           step_ax;
    logic [TIME_W:0]      sat_sum;
    logic [TIME_W-1:0]    new_time;
    logic [TIME_W-1:0]    t_after [3];
    logic                 all_past;
    logic                 go_walk;
    logic [7:0]           limit_init;
    logic                 accept;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_RAY_RANGE) ? {26'd0, range_reg} : 32'd0;
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    assign m_valid  = m_valid_reg;
    assign m_hit    = m_hit_reg;
    assign m_hit_x  = m_hx_reg;
    assign m_hit_y  = m_hy_reg;
    assign m_hit_z  = m_hz_reg;
    assign m_face_x = m_fx_reg;
    assign m_face_y = m_fy_reg;
    assign m_face_z = m_fz_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            occ_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= occ_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg <= RANGE_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_RAY_RANGE) begin
            range_reg <= pwdata[RANGE_W-1:0];
        end
    end

    // Per-axis helpers: magnitudes, start voxel and distance to first plane.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            abs_dir[k] = dir_reg[k][DIR_W-1] ? DIR_W'(-dir_reg[k]) : DIR_W'(dir_reg[k]);
            oe_reg[k]  = {{FRAC_BITS{1'b0}}, org_reg[k]};
            plane_dist[k] = dir_reg[k][DIR_W-1] ? {1'b0, oe_reg[k][FRAC_BITS-1:0]}
                : ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, oe_reg[k][FRAC_BITS-1:0]};
        end
        oe_in[0] = {{FRAC_BITS{1'b0}}, s_origin_x};
        oe_in[1] = {{FRAC_BITS{1'b0}}, s_origin_y};
        oe_in[2] = {{FRAC_BITS{1'b0}}, s_origin_z};
        for (int k = 0; k < 3; k++) begin
            org_cell[k] = WCW'(oe_in[k] >> FRAC_BITS);
        end
    end

    // The one multiplier, shared by squares, divisor setup and time scaling.
    always_comb begin
        unique case (state_reg)
            S_AXM: begin
                mul_a = TIME_W'(abs_dir[ax_reg]);
                mul_b = MB'(range_reg);
            end
            S_CTM: begin
                mul_a = dq_reg;
                mul_b = MB'(plane_dist[ax_reg]);
            end
            default: begin
                mul_a = TIME_W'(abs_dir[ax_reg]);
                mul_b = MB'(abs_dir[ax_reg]);
            end
        endcase
        prod_next = PW'(mul_a) * PW'(mul_b);
    end

    always_comb begin
        in_grid = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (wc_reg[k] < 0 || wc_reg[k] >= WCW'(GRID_SIDE)) begin
                in_grid = 1'b0;
            end
        end
        cell_ok = (WCW'(s_cell_x) < WCW'(GRID_SIDE)) && (WCW'(s_cell_y) < WCW'(GRID_SIDE))
               && (WCW'(s_cell_z) < WCW'(GRID_SIDE));

        sumsq_add = sumsq_reg + prod_reg[TIME_W-1:0];
        sq_t      = sq_r_reg + sq_b_reg;
        rem2      = {rem_reg, dq_reg[TIME_W-1]};
        div_ge    = rem2 >= {1'b0, d_reg};

        // Smallest crossing time; ties go to z, then y.
        if (ctime_reg[0] < ctime_reg[1]) begin
            step_ax = (ctime_reg[0] < ctime_reg[2]) ? AX_X : AX_Z;
        end else begin
            step_ax = (ctime_reg[1] < ctime_reg[2]) ? AX_Y : AX_Z;
        end
        sat_sum  = {1'b0, ctime_reg[step_ax]} + {1'b0, cstep_reg[step_ax]};
        new_time = sat_sum[TIME_W] ? TIME_MAX : sat_sum[TIME_W-1:0];
        for (int k = 0; k < 3; k++) begin
            t_after[k] = (step_ax == 2'(k)) ? new_time : ctime_reg[k];
        end
        all_past = (t_after[0] > TIME_ONE) && (t_after[1] > TIME_ONE) && (t_after[2] > TIME_ONE);

        if (range_reg == '0) begin
            limit_init = 8'd0;
        end else begin
            limit_init = 8'({range_reg, 1'b0}) + 8'(range_reg) - 8'd1;
            if (sumsq_reg == '0 && limit_init > 8'd1) begin
                limit_init = 8'd1;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        wc_next      = wc_reg;
        org_next     = org_reg;
        dir_next     = dir_reg;
        solid_next   = solid_reg;
        cnt_next     = cnt_reg;
        ax_next      = ax_reg;
        sumsq_next   = sumsq_reg;
        sq_n_next    = sq_n_reg;
        sq_r_next    = sq_r_reg;
        sq_b_next    = sq_b_reg;
        d_next       = d_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        cstep_next   = cstep_reg;
        ctime_next   = ctime_reg;
        last_ax_next = last_ax_reg;
        tests_next   = tests_reg;
        limit_next   = limit_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_hit_next   = m_hit_reg;
        m_hx_next    = m_hx_reg;
        m_hy_next    = m_hy_reg;
        m_hz_next    = m_hz_reg;
        m_fx_next    = m_fx_reg;
        m_fy_next    = m_fy_reg;
        m_fz_next    = m_fz_reg;
        mem_we       = 1'b0;
        mem_addr     = {wc_reg[2][CW-1:0], wc_reg[1][CW-1:0]};
        mem_wdata    = mem_rdata_reg;
        go_walk      = 1'b0;

        unique case (state_reg)
            S_CLR: begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(ROWS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (s_req_type == REQ_WRITE) begin
                        wc_next[0] = WCW'(s_cell_x);
                        wc_next[1] = WCW'(s_cell_y);
                        wc_next[2] = WCW'(s_cell_z);
                        solid_next = s_solid;
                        if (cell_ok) begin
                            state_next = S_WRD;
                        end
                    end else begin
                        org_next[0] = s_origin_x;
                        org_next[1] = s_origin_y;
                        org_next[2] = s_origin_z;
                        dir_next[0] = s_dir_x;
                        dir_next[1] = s_dir_y;
                        dir_next[2] = s_dir_z;
                        wc_next     = org_cell;
                        cnt_next    = '0;
                        ax_next     = AX_X;
                        sumsq_next  = '0;
                        state_next  = S_SQ;
                    end
                end
            end
            S_WRD: begin
                state_next = S_WMOD;
            end
            S_WMOD: begin
                mem_we = 1'b1;
                mem_wdata[wc_reg[0][CW-1:0]] = solid_reg;
                state_next = S_IDLE;
            end
            S_SQ: begin
                // Square of axis n is issued at count n and summed from the registered product in the next cycle.
                if (cnt_reg != '0) begin
                    sumsq_next = sumsq_add;
                end
                ax_next  = (ax_reg == AX_Z) ? AX_Z : ax_reg + 2'd1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd3) begin
                    sq_n_next  = {sumsq_add, 32'd0};
                    sq_r_next  = '0;
                    sq_b_next  = 64'd1 << 62;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (sq_n_reg >= sq_t) begin
                    sq_n_next = sq_n_reg - sq_t;
                    sq_r_next = (sq_r_reg >> 1) + sq_b_reg;
                end else begin
                    sq_r_next = sq_r_reg >> 1;
                end
                sq_b_next = sq_b_reg >> 2;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    ax_next    = AX_X;
                    state_next = S_AXM;
                end
            end
            S_AXM: begin
                if (dir_reg[ax_reg] == '0 || range_reg == '0) begin
                    cstep_next[ax_reg] = TIME_MAX;
                    ctime_next[ax_reg] = TIME_MAX;
                    if (ax_reg == AX_Z) begin
                        go_walk = 1'b1;
                    end else begin
                        ax_next = ax_reg + 2'd1;
                    end
                end else begin
                    state_next = S_DIVI;
                end
            end
            S_DIVI: begin
                d_next     = prod_reg[DW-1:0];
                rem_next   = '0;
                dq_next    = sq_r_reg[TIME_W-1:0];
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                rem_next = div_ge ? DW'(rem2 - {1'b0, d_reg}) : DW'(rem2);
                dq_next  = {dq_reg[TIME_W-2:0], div_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    cstep_next[ax_reg] = {dq_reg[TIME_W-2:0], div_ge};
                    state_next = S_CTM;
                end
            end
            S_CTM: begin
                state_next = S_CTW;
            end
            S_CTW: begin
                ctime_next[ax_reg] = TIME_W'(prod_reg >> FRAC_BITS);
                if (ax_reg == AX_Z) begin
                    go_walk = 1'b1;
                end else begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = S_AXM;
                end
            end
            S_RD: begin
                state_next = S_TEST;
            end
            S_TEST: begin
                tests_next = tests_reg + 8'd1;
                if (in_grid && mem_rdata_reg[wc_reg[0][CW-1:0]]) begin
                    hit_next   = 1'b1;
                    state_next = S_FIN;
                end else begin
                    ctime_next[step_ax] = new_time;
                    last_ax_next        = step_ax;
                    if (dir_reg[step_ax][DIR_W-1]) begin
                        wc_next[step_ax] = wc_reg[step_ax] - WCW'(1);
                    end else if (dir_reg[step_ax] != '0) begin
                        wc_next[step_ax] = wc_reg[step_ax] + WCW'(1);
                    end
                    if (all_past || tests_reg + 8'd1 >= limit_reg) begin
                        state_next = S_FIN;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = hit_reg;
                    m_hx_next    = hit_reg ? wc_reg[0][CELL_W-1:0] : '0;
                    m_hy_next    = hit_reg ? wc_reg[1][CELL_W-1:0] : '0;
                    m_hz_next    = hit_reg ? wc_reg[2][CELL_W-1:0] : '0;
                    m_fx_next    = '0;
                    m_fy_next    = '0;
                    m_fz_next    = '0;
                    // The face normal points against the last step.
                    if (hit_reg && last_ax_reg != AX_NONE && dir_reg[last_ax_reg] != '0) begin
                        unique case (last_ax_reg)
                            AX_X:    m_fx_next = dir_reg[0][DIR_W-1] ? 2'sb01 : 2'sb11;
                            AX_Y:    m_fy_next = dir_reg[1][DIR_W-1] ? 2'sb01 : 2'sb11;
                            default: m_fz_next = dir_reg[2][DIR_W-1] ? 2'sb01 : 2'sb11;
                        endcase
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (go_walk) begin
            last_ax_next = AX_NONE;
            tests_next   = '0;
            hit_next     = 1'b0;
            limit_next   = limit_init;
            state_next   = (limit_init == '0) ? S_FIN : S_RD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            ax_reg      <= AX_X;
            last_ax_reg <= AX_NONE;
            tests_reg   <= '0;
            limit_reg   <= '0;
            hit_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            ax_reg      <= ax_next;
            last_ax_reg <= last_ax_next;
            tests_reg   <= tests_next;
            limit_reg   <= limit_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        wc_reg    <= wc_next;
        org_reg   <= org_next;
        dir_reg   <= dir_next;
        solid_reg <= solid_next;
        prod_reg  <= prod_next;
        sumsq_reg <= sumsq_next;
        sq_n_reg  <= sq_n_next;
        sq_r_reg  <= sq_r_next;
        sq_b_reg  <= sq_b_next;
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        dq_reg    <= dq_next;
        cstep_reg <= cstep_next;
        ctime_reg <= ctime_next;
        m_hit_reg <= m_hit_next;
        m_hx_reg  <= m_hx_next;
        m_hy_reg  <= m_hy_next;
        m_hz_reg  <= m_hz_next;
        m_fx_reg  <= m_fx_next;
        m_fy_reg  <= m_fy_next;
        m_fz_reg  <= m_fz_next;
    end

    a_test_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TEST) |-> (tests_reg < limit_reg))
        else $error("voxel test beyond the test limit");

    a_root_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SQRT) |-> (sq_b_reg != '0))
        else $error("square root ran out of bits");

    a_one_face: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ($countones({m_fx_reg != 2'sb00, m_fy_reg != 2'sb00,
                                     m_fz_reg != 2'sb00}) <= 1))
        else $error("more than one face axis set");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_hit_reg) |-> (m_hx_reg == '0 && m_hy_reg == '0 &&
                                         m_hz_reg == '0 && m_fx_reg == 2'sb00))
        else $error("miss word carries a voxel");

endmodule
